/* hdl/pdu_pkg.sv */
// ----------------------------------------------------------------------------
// pdu_pkg
// Shared constants for the point distance unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pdu_pkg;

  // Default coordinate width (signed two's complement, fixed point).
  localparam int COORD_WIDTH_DEF = 24;

  // Operation codes carried on the op field.
  localparam logic OP_PLANAR = 1'b0;
  localparam logic OP_FULL   = 1'b1;

endpackage

`default_nettype wire

/* hdl/pdu_in_if.sv */
// ----------------------------------------------------------------------------
// pdu_in_if
// Input channel: mode bit and two points, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdu_in_if #(
  parameter int COORD_WIDTH = pdu_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic signed [COORD_WIDTH-1:0] ax;
  logic signed [COORD_WIDTH-1:0] ay;
  logic signed [COORD_WIDTH-1:0] az;
  logic signed [COORD_WIDTH-1:0] bx;
  logic signed [COORD_WIDTH-1:0] by;
  logic signed [COORD_WIDTH-1:0] bz;

  modport source (
    output valid, op, ax, ay, az, bx, by, bz,
    input  ready
  );

  modport sink (
    input  valid, op, ax, ay, az, bx, by, bz,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/pdu_out_if.sv */
// ----------------------------------------------------------------------------
// pdu_out_if
// Result channel: unsigned distance, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdu_out_if #(
  parameter int COORD_WIDTH = pdu_pkg::COORD_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH:0]   distance;

  modport source (
    output valid, distance,
    input  ready
  );

  modport sink (
    input  valid, distance,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/pdu_front.sv */
// ----------------------------------------------------------------------------
// pdu_front
// Front end: per-axis absolute differences, squares, and sum of squares.
// ----------------------------------------------------------------------------
`default_nettype none

module pdu_front #(
  parameter int COORD_WIDTH = pdu_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic                          op,
  input  wire logic signed [COORD_WIDTH-1:0] ax,
  input  wire logic signed [COORD_WIDTH-1:0] ay,
  input  wire logic signed [COORD_WIDTH-1:0] az,
  input  wire logic signed [COORD_WIDTH-1:0] bx,
  input  wire logic signed [COORD_WIDTH-1:0] by,
  input  wire logic signed [COORD_WIDTH-1:0] bz,
  output logic                               sum_valid,
  output logic [2*COORD_WIDTH+1:0]           sum
);
  import pdu_pkg::*;

  localparam int MAG_W = COORD_WIDTH + 1;
  localparam int SQ_W  = 2 * MAG_W;

  logic [MAG_W-1:0] dx, dy, dz;
  logic [MAG_W-1:0] mx_nxt, my_nxt, mz_nxt;
  logic [MAG_W-1:0] mx_r, my_r, mz_r;
  logic [SQ_W-1:0]  sx_r, sy_r, sz_r;
  logic [SQ_W-1:0]  sum_r;
  logic             v1_r, v2_r, v3_r;

  function automatic logic [MAG_W-1:0] abs_of(input logic [MAG_W-1:0] d);
    abs_of = d[MAG_W-1] ? (~d + MAG_W'(1)) : d;
  endfunction

  // Sign-extended differences; the magnitude always fits the extended width.
  assign dx = MAG_W'({ax[COORD_WIDTH-1], ax}) - MAG_W'({bx[COORD_WIDTH-1], bx});
  assign dy = MAG_W'({ay[COORD_WIDTH-1], ay}) - MAG_W'({by[COORD_WIDTH-1], by});
  assign dz = MAG_W'({az[COORD_WIDTH-1], az}) - MAG_W'({bz[COORD_WIDTH-1], bz});

  always_comb begin
    mx_nxt = abs_of(dx);
    mz_nxt = abs_of(dz);
    // Planar mode drops the y axis.
    my_nxt = (op == OP_FULL) ? abs_of(dy) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r  <= mx_nxt;
      my_r  <= my_nxt;
      mz_r  <= mz_nxt;
      sx_r  <= mx_r * mx_r;
      sy_r  <= my_r * my_r;
      sz_r  <= mz_r * mz_r;
      // Three squares of at most 2^(2W) each stay below 2^(2W+2).
      sum_r <= sx_r + sy_r + sz_r;
    end
  end

  assign sum_valid = v3_r;
  assign sum       = sum_r;

endmodule

`default_nettype wire

/* hdl/pdu_root_cell.sv */
// ----------------------------------------------------------------------------
// pdu_root_cell
// One step of a restoring square root: takes the next radicand bit pair,
// tries the trial subtrahend and hands remainder, root and radicand onward.
// ----------------------------------------------------------------------------
`default_nettype none

module pdu_root_cell #(
  parameter int COORD_WIDTH = pdu_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       valid_in,
  input  wire logic [2*COORD_WIDTH+1:0]   rad_in,
  input  wire logic [COORD_WIDTH+1:0]     rem_in,
  input  wire logic [COORD_WIDTH:0]       root_in,
  output logic                            valid_out,
  output logic [2*COORD_WIDTH+1:0]        rad_out,
  output logic [COORD_WIDTH+1:0]          rem_out,
  output logic [COORD_WIDTH:0]            root_out
);
  import pdu_pkg::*;

  localparam int SUM_W  = 2 * COORD_WIDTH + 2;
  localparam int ROOT_W = COORD_WIDTH + 1;
  localparam int REM_W  = COORD_WIDTH + 2;
  localparam int TRY_W  = COORD_WIDTH + 3;

  logic [TRY_W-1:0]  rem_try;
  logic [TRY_W-1:0]  trial;
  logic [TRY_W-1:0]  diff;
  logic              fits;
  logic              valid_r;
  logic [SUM_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;

  // Incoming remainder is always below 2^(W+1), so its top bit is dropped.
  assign rem_try = {rem_in[REM_W-2:0], rad_in[SUM_W-1 -: 2]};
  assign trial   = {root_in, 2'b01};
  assign diff    = rem_try - trial;
  assign fits    = (rem_try >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= {rad_in[SUM_W-3:0], 2'b00};
      rem_r  <= fits ? diff[REM_W-1:0] : rem_try[REM_W-1:0];
      root_r <= {root_in[ROOT_W-2:0], fits};
    end
  end

  assign valid_out = valid_r;
  assign rad_out   = rad_r;
  assign rem_out   = rem_r;
  assign root_out  = root_r;

endmodule

`default_nettype wire

/* hdl/point_distance_unit_top.sv */
// ----------------------------------------------------------------------------
// point_distance_unit_top
// Euclidean distance between two fixed-point points, planar or 3D.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : one item per handshake (valid & ready) carrying op and the two
//            points ax..az, bx..bz. op = 0 gives the distance over x and z,
//            op = 1 the full distance over x, y and z.
//   out_if : one item per input item, distance = floor(sqrt(sum of squared
//            differences)), same fixed-point scale as the coordinates.
// Pipeline: from acceptance to out_if.valid an item passes three front stages
//   (difference, square, sum), one cell per root bit (COORD_WIDTH + 1 cells),
//   and the output register.
// Throughput: one item per cycle; the chain of root cells advances every
//   cycle that the skid register is empty.
// Reset: rst_n clears every valid bit; nothing else needs clearing and no
//   warm-up is required.
// Stall: when out_if.ready is low the output register holds its item and one
//   more item from the chain lands in the skid register; in_if.ready then
//   drops and the whole chain holds until the skid drains. in_if.ready
//   depends on registers only.
// ----------------------------------------------------------------------------
`default_nettype none

module point_distance_unit_top #(
  parameter int COORD_WIDTH = pdu_pkg::COORD_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pdu_in_if.sink    in_if,
  pdu_out_if.source out_if
);
  import pdu_pkg::*;

  localparam int SUM_W  = 2 * COORD_WIDTH + 2;
  localparam int ROOT_W = COORD_WIDTH + 1;
  localparam int REM_W  = COORD_WIDTH + 2;
  localparam int CELLS  = ROOT_W;

  logic              adv;
  logic              sum_valid;
  logic [SUM_W-1:0]  sum;

  // Chain taps: index 0 feeds the first cell, index CELLS is the last output.
  logic              vld  [CELLS+1];
  logic [SUM_W-1:0]  rad  [CELLS+1];
  logic [REM_W-1:0]  rem  [CELLS+1];
  logic [ROOT_W-1:0] root [CELLS+1];

  logic              out_valid_r;
  logic [ROOT_W-1:0] out_dist_r;
  logic              skid_valid_r;
  logic [ROOT_W-1:0] skid_dist_r;

  // Advance the pipe whenever the skid register is free.
  assign adv         = !skid_valid_r;
  assign in_if.ready = adv;

  pdu_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_if.valid),
    .op        (in_if.op),
    .ax        (in_if.ax),
    .ay        (in_if.ay),
    .az        (in_if.az),
    .bx        (in_if.bx),
    .by        (in_if.by),
    .bz        (in_if.bz),
    .sum_valid (sum_valid),
    .sum       (sum)
  );

  // Start the root with empty remainder and root.
  assign vld[0]  = sum_valid;
  assign rad[0]  = sum;
  assign rem[0]  = '0;
  assign root[0] = '0;

  // One cell per root bit, most significant bit pair first.
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    pdu_root_cell #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .valid_in  (vld[i]),
      .rad_in    (rad[i]),
      .rem_in    (rem[i]),
      .root_in   (root[i]),
      .valid_out (vld[i+1]),
      .rad_out   (rad[i+1]),
      .rem_out   (rem[i+1]),
      .root_out  (root[i+1])
    );
  end

  // Output register plus skid: hold while stalled, catch the item that
  // leaves the chain in the same cycle, drain the skid first once free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && !out_if.ready) begin
      if (adv && vld[CELLS]) begin
        skid_valid_r <= 1'b1;
      end
    end else if (skid_valid_r) begin
      out_valid_r  <= 1'b1;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld[CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && !out_if.ready) begin
      if (adv && vld[CELLS]) begin
        skid_dist_r <= root[CELLS];
      end
    end else if (skid_valid_r) begin
      out_dist_r <= skid_dist_r;
    end else begin
      out_dist_r <= root[CELLS];
    end
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.distance = out_dist_r;

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for point_distance_unit_top. Each accepted query is run
// through a bit-exact distance predictor (exact sum of squared differences,
// floored integer square root) and the expected distance is queued. Every
// result item is checked against the oldest queued distance. The stimulus is
// a short directed set followed by random queries, under changing handshake
// idling and one long output stall.
// ----------------------------------------------------------------------------
module tb;
  import pdu_pkg::*;

  localparam int CW         = COORD_WIDTH_DEF;
  localparam int FRAC       = 8;
  localparam int N_RANDOM   = 634;
  localparam int DRAIN      = CW + 16;
  localparam int HOLD_LEN   = 300;
  localparam int CYCLE_CAP  = 200000;
  localparam int MAX_REPORT = 10;

  localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  // One distance query as it travels on the input channel.
  typedef struct packed {
    logic          op;
    logic [CW-1:0] ax, ay, az;
    logic [CW-1:0] bx, by, bz;
  } pt_query_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  pdu_in_if  #(.COORD_WIDTH(CW)) in_ch();
  pdu_out_if #(.COORD_WIDTH(CW)) out_ch();

  point_distance_unit_top #(.COORD_WIDTH(CW)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always #2 clk = ~clk;

  pt_query_t     query_q[$];         // queries not yet offered
  logic [CW:0]   pending_dist_q[$];  // distances owed by the block, oldest first
  int            total_items = 0;
  int            accepted    = 0;
  int            err_cnt     = 0;
  int            cycles      = 0;
  int            hold_left   = 0;
  logic          hold_done   = 1'b0;
  int            send_idle_pct;
  int            recv_idle_pct;

  // Distance predictor: exact squared differences, one floored square root.
  // Planar mode skips the y axis entirely.
  function automatic logic [CW:0] floor_distance(pt_query_t q);
    logic signed [CW:0] dx, dy, dz;
    logic [CW:0]        mag;
    logic [2*CW+1:0]    wide;
    logic [2*CW+1:0]    sum;
    logic [63:0]        rem, root, trial;
    dx  = $signed(q.ax) - $signed(q.bx);
    dy  = $signed(q.ay) - $signed(q.by);
    dz  = $signed(q.az) - $signed(q.bz);
    sum = '0;
    mag = dx[CW] ? -dx : dx;
    wide = mag;
    sum += wide * wide;
    mag = dz[CW] ? -dz : dz;
    wide = mag;
    sum += wide * wide;
    if (q.op == OP_FULL) begin
      mag = dy[CW] ? -dy : dy;
      wide = mag;
      sum += wide * wide;
    end
    // restoring root, two bits of the radicand per step
    rem  = '0;
    root = '0;
    for (int i = CW; i >= 0; i--) begin
      rem   = (rem << 2) | sum[2*i +: 2];
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[CW:0];
  endfunction

  task automatic add_query(input logic op,
                           input logic [CW-1:0] ax, ay, az, bx, by, bz);
    pt_query_t q;
    q.op = op;
    q.ax = ax; q.ay = ay; q.az = az;
    q.bx = bx; q.by = by; q.bz = bz;
    query_q.push_back(q);
  endtask

  // style 0: any value; 1: an extreme, zero or plus or minus one; otherwise a small value around zero
  function automatic logic [CW-1:0] pick_coord(int style);
    logic [CW-1:0] v;
    case (style)
      0: begin
        v = CW'($urandom());
      end
      1: begin
        case ($urandom_range(4))
          0:       v = CMAX;
          1:       v = CMIN;
          2:       v = '0;
          3:       v = '1;
          default: v = CW'(1);
        endcase
      end
      default: begin
        v = CW'(int'($urandom_range(1023)) - 512);
      end
    endcase
    return v;
  endfunction

  // Idling schedule by progress: sender 15 / receiver 77, then swapped, then
  // no idling at all for the last third.
  always_comb begin
    if (accepted < total_items / 3) begin
      send_idle_pct = 15;
      recv_idle_pct = 77;
    end else if (accepted < 2 * total_items / 3) begin
      send_idle_pct = 77;
      recv_idle_pct = 15;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // Driver: advance to the next query only once the current one is taken.
  always @(posedge clk) begin : drv
    pt_query_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.op    <= OP_PLANAR;
      in_ch.ax    <= '0;
      in_ch.ay    <= '0;
      in_ch.az    <= '0;
      in_ch.bx    <= '0;
      in_ch.by    <= '0;
      in_ch.bz    <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (query_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = query_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.op    <= nxt.op;
        in_ch.ax    <= nxt.ax;
        in_ch.ay    <= nxt.ay;
        in_ch.az    <= nxt.az;
        in_ch.bx    <= nxt.bx;
        in_ch.by    <= nxt.by;
        in_ch.bz    <= nxt.bz;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Input monitor: predict the distance of every accepted item.
  always @(posedge clk) begin : in_mon
    pt_query_t seen;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen.op = in_ch.op;
      seen.ax = in_ch.ax; seen.ay = in_ch.ay; seen.az = in_ch.az;
      seen.bx = in_ch.bx; seen.by = in_ch.by; seen.bz = in_ch.bz;
      pending_dist_q.push_back(floor_distance(seen));
      accepted <= accepted + 1;
    end
  end

  // Long output stall: once, late in the no-idle phase, hold ready low so the
  // pipeline fills and the block must drop its input ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted >= total_items - 120) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: random back-pressure, forced off during the long stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Output monitor: compare each result item with the oldest expectation.
  always @(posedge clk) begin : out_mon
    logic [CW:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_dist_q.size() == 0) begin
        err_cnt <= err_cnt + 1;
        if (err_cnt < MAX_REPORT)
          $display("ERROR: result item with nothing expected, distance=%0d",
                   out_ch.distance);
      end else begin
        want = pending_dist_q.pop_front();
        if (out_ch.distance !== want) begin
          err_cnt <= err_cnt + 1;
          if (err_cnt < MAX_REPORT)
            $display("ERROR: distance mismatch, expected %0d got %0d",
                     want, out_ch.distance);
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("ERROR: timeout with %0d items accepted of %0d", accepted, total_items);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : main
    pt_query_t     q;
    int            style;
    logic [CW-1:0] r0, r1, r2;

    // Directed part: zero distance, full-scale extremes in both modes, exact
    // integer distances, y ignored in planar mode, one-lsb steps, origin cases.
    add_query(OP_PLANAR, '0, '0, '0, '0, '0, '0);
    add_query(OP_FULL,   '0, '0, '0, '0, '0, '0);
    add_query(OP_FULL,   CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
    add_query(OP_PLANAR, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
    add_query(OP_FULL,   CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    add_query(OP_PLANAR, CW'(3 << FRAC), CMAX, CW'(4 << FRAC), '0, CMIN, '0);
    add_query(OP_FULL,   CW'(2 << FRAC), CW'(3 << FRAC), CW'(6 << FRAC), '0, '0, '0);
    add_query(OP_FULL,   '1, '1, '1, '0, '0, '0);
    add_query(OP_PLANAR, CW'(1), '0, '0, '0, '0, '0);
    add_query(OP_FULL,   '0, CMAX, '0, '0, CMIN, '0);
    add_query(OP_PLANAR, '0, '0, CMIN, '0, '0, CMAX);
    r0 = CW'($urandom()); r1 = CW'($urandom()); r2 = CW'($urandom());
    add_query(OP_FULL,   r0, r1, r2, '0, '0, '0);
    add_query(OP_PLANAR, r2, r0, r1, '0, '0, '0);
    add_query(OP_FULL,   r1, r2, r0, r1, r2, r0);
    add_query(OP_FULL,   {(CW/2){2'b10}}, {(CW/2){2'b10}}, {(CW/2){2'b10}},
                         {(CW/2){2'b01}}, {(CW/2){2'b01}}, {(CW/2){2'b01}});
    add_query(OP_PLANAR, {(CW/2){2'b01}}, {(CW/2){2'b10}}, {(CW/2){2'b01}},
                         {(CW/2){2'b10}}, {(CW/2){2'b01}}, {(CW/2){2'b10}});

    // Random part: mostly arbitrary points, with close pairs, origin queries,
    // extremes and small coordinates mixed in.
    for (int n = 0; n < N_RANDOM; n++) begin
      style = $urandom_range(9);
      q.op  = $urandom_range(1) ? OP_FULL : OP_PLANAR;
      if (style <= 4) begin
        q.ax = pick_coord(0); q.ay = pick_coord(0); q.az = pick_coord(0);
        q.bx = pick_coord(0); q.by = pick_coord(0); q.bz = pick_coord(0);
      end else if (style <= 6) begin
        // close pair: offset a point by -512 to 511 lsbs, wrapping at full scale
        q.ax = pick_coord(0); q.ay = pick_coord(0); q.az = pick_coord(0);
        q.bx = q.ax + pick_coord(2);
        q.by = q.ay + pick_coord(2);
        q.bz = q.az + pick_coord(2);
      end else if (style == 7) begin
        q.ax = pick_coord(0); q.ay = pick_coord(0); q.az = pick_coord(0);
        q.bx = '0; q.by = '0; q.bz = '0;
      end else if (style == 8) begin
        q.ax = pick_coord(1); q.ay = pick_coord(1); q.az = pick_coord(1);
        q.bx = pick_coord(1); q.by = pick_coord(1); q.bz = pick_coord(1);
      end else begin
        q.ax = pick_coord(2); q.ay = pick_coord(2); q.az = pick_coord(2);
        q.bx = pick_coord(2); q.by = pick_coord(2); q.bz = pick_coord(2);
      end
      query_q.push_back(q);
    end
    total_items = query_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every query to be taken, every distance to come back, then
    // keep clocking to catch stray result items
    while (accepted < total_items) @(posedge clk);
    while (pending_dist_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
